// ----- design/rpaar_pkg.sv -----
// Package for the radio packet auto-ack responder.
// Holds packet layout constants, register indexes and the ack field bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rpaar_pkg;

    localparam int MAX_PACKET_BYTES = 128;
    localparam int POS_W            = $clog2(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES - 1);

    localparam int ADDR_W  = 24;
    localparam int ACK_LEN = 12;
    localparam int IDX_W   = $clog2(ACK_LEN);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ACK_LEN - 1);

    // Received packet byte positions.
    localparam logic [POS_W-1:0] POS_LEN  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_CNT  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TYPE = POS_W'(3);
    localparam logic [POS_W-1:0] POS_SRC0 = POS_W'(4);
    localparam logic [POS_W-1:0] POS_SRC1 = POS_W'(5);
    localparam logic [POS_W-1:0] POS_SRC2 = POS_W'(6);
    localparam logic [POS_W-1:0] POS_DST0 = POS_W'(7);
    localparam logic [POS_W-1:0] POS_DST1 = POS_W'(8);
    localparam logic [POS_W-1:0] POS_DST2 = POS_W'(9);

    // Message types and ack constants.
    localparam logic [7:0] TYPE_A      = 8'h30;
    localparam logic [7:0] TYPE_B      = 8'h40;
    localparam logic [7:0] TYPE_C      = 8'h50;
    localparam logic [7:0] THERMO_LEN  = 8'd11;
    localparam logic [7:0] ACK_LEN_BYTE = 8'd11;
    localparam logic [7:0] ACK_TYPE    = 8'd2;

    typedef enum logic {
        REG_AUTO_ACK_ADDR = 1'b0,
        REG_THERMO_ADDR   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]        counter;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
    } t_ack_fields;

endpackage

`default_nettype wire

// ----- design/radio_packet_auto_ack_responder.sv -----
// Top level of the radio packet auto-ack responder: header capture and ack decision.
// Depends on rpaar_pkg and instantiates rpaar_ack_tx.
//
//   channel   direction  handshake            payload
//   rx        in         i_valid / o_ready    i_rx_byte, i_frame_end
//   ack       out        o_valid / i_ready    o_ack_byte, o_ack_packet_end, o_run_last
//   cfg       in         i_cfg_we             i_cfg_addr, i_cfg_wdata
//
// A received word is taken every cycle while no ack is being sent; the decision is
// made in the cycle the last word is taken. A match sends 12 words per ack (24 if
// both fire), one per cycle while i_ready is high; rx is held off until the final
// ack word is taken. In the cycle it leaves, the next received word is already taken.
// Reset (synchronous, active low) clears all captured fields and both addresses.
`timescale 1ns / 1ps
`default_nettype none

module radio_packet_auto_ack_responder
    import rpaar_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [ADDR_W-1:0] i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_rx_byte,
    input  wire logic              i_frame_end,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_ack_byte,
    output logic                   o_ack_packet_end,
    output logic                   o_run_last
);

    logic [ADDR_W-1:0] r_auto_addr, r_thermo_addr;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_len, n_len;
    logic [7:0]        r_cnt, n_cnt;
    logic [7:0]        r_type, n_type;
    logic [ADDR_W-1:0] r_src, n_src;
    logic [ADDR_W-1:0] r_dst, n_dst;

    logic        accept;
    logic        tx_busy;
    logic        auto_hit, thermo_hit, long_enough;
    logic        start, two;
    t_ack_fields fields;

    assign o_ready = !tx_busy || (o_valid && i_ready && o_run_last);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_addr   <= '0;
            r_thermo_addr <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_AUTO_ACK_ADDR: r_auto_addr   <= i_cfg_wdata;
                REG_THERMO_ADDR:   r_thermo_addr <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Field capture by byte position.
    always_comb begin
        n_len  = r_len;
        n_cnt  = r_cnt;
        n_type = r_type;
        n_src  = r_src;
        n_dst  = r_dst;
        unique case (r_pos)
            POS_LEN:  n_len  = i_rx_byte;
            POS_CNT:  n_cnt  = i_rx_byte;
            POS_TYPE: n_type = i_rx_byte;
            POS_SRC0: n_src[23:16] = i_rx_byte;
            POS_SRC1: n_src[15:8]  = i_rx_byte;
            POS_SRC2: n_src[7:0]   = i_rx_byte;
            POS_DST0: n_dst[23:16] = i_rx_byte;
            POS_DST1: n_dst[15:8]  = i_rx_byte;
            POS_DST2: n_dst[7:0]   = i_rx_byte;
            default: ;
        endcase
        if (i_frame_end) begin
            n_pos = '0;
        end else if (r_pos != POS_MAX) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    assign long_enough = (r_pos >= POS_DST2);
    assign auto_hit    = (r_auto_addr != '0)
                      && (n_type == TYPE_A || n_type == TYPE_B || n_type == TYPE_C)
                      && (n_dst == r_auto_addr);
    assign thermo_hit  = (r_thermo_addr != '0) && (n_len == THERMO_LEN)
                      && (n_type == TYPE_B) && (n_dst == r_thermo_addr);
    assign start = accept && i_frame_end && long_enough && (auto_hit || thermo_hit);
    assign two   = auto_hit && thermo_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_cnt  <= '0;
            r_type <= '0;
            r_src  <= '0;
            r_dst  <= '0;
        end else if (accept) begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_cnt  <= n_cnt;
            r_type <= n_type;
            r_src  <= n_src;
            r_dst  <= n_dst;
        end
    end

    assign fields.counter = r_cnt;
    assign fields.src     = r_src;
    assign fields.dst     = r_dst;

    rpaar_ack_tx u_ack_tx (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_two            (two),
        .i_fields         (fields),
        .o_busy           (tx_busy),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_ack_byte       (o_ack_byte),
        .o_ack_packet_end (o_ack_packet_end),
        .o_run_last       (o_run_last)
    );

endmodule

`default_nettype wire

// ----- design/rpaar_ack_tx.sv -----
// Ack packet transmitter: streams one or two 12-byte ack packets.
// Depends on rpaar_pkg for layout constants and the field bundle.
`timescale 1ns / 1ps
`default_nettype none

module rpaar_ack_tx
    import rpaar_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_two,
    input  wire t_ack_fields i_fields,
    output logic             o_busy,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_ack_byte,
    output logic             o_ack_packet_end,
    output logic             o_run_last
);

    logic             r_busy, n_busy;
    logic             r_more, n_more;
    logic [IDX_W-1:0] r_idx,  n_idx;
    logic             pkt_end;

    assign pkt_end          = (r_idx == IDX_LAST);
    assign o_busy           = r_busy;
    assign o_valid          = r_busy;
    assign o_ack_packet_end = pkt_end;
    assign o_run_last       = pkt_end && !r_more;

    always_comb begin
        case (r_idx)
            IDX_W'(0): o_ack_byte = ACK_LEN_BYTE;
            IDX_W'(1): o_ack_byte = i_fields.counter;
            IDX_W'(3): o_ack_byte = ACK_TYPE;
            IDX_W'(4): o_ack_byte = i_fields.dst[23:16];
            IDX_W'(5): o_ack_byte = i_fields.dst[15:8];
            IDX_W'(6): o_ack_byte = i_fields.dst[7:0];
            IDX_W'(7): o_ack_byte = i_fields.src[23:16];
            IDX_W'(8): o_ack_byte = i_fields.src[15:8];
            IDX_W'(9): o_ack_byte = i_fields.src[7:0];
            default:   o_ack_byte = 8'd0;
        endcase
    end

    always_comb begin
        n_busy = r_busy;
        n_more = r_more;
        n_idx  = r_idx;
        if (r_busy && i_ready) begin
            if (pkt_end) begin
                n_idx  = '0;
                n_more = 1'b0;
                n_busy = r_more;
            end else begin
                n_idx = r_idx + IDX_W'(1);
            end
        end
        // A start only arrives when the stream is idle or just finishing.
        if (i_start) begin
            n_busy = 1'b1;
            n_more = i_two;
            n_idx  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_more <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_busy <= n_busy;
            r_more <= n_more;
            r_idx  <= n_idx;
        end
    end

endmodule

`default_nettype wire
